// ===== rtl/sot_pkg.sv =====
package sot_pkg;

    // register indexes of the configuration port
    localparam int REG_IDX_BITS = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_OWN_IS_BOX   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_OWN_OFFSET_X = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_OWN_OFFSET_Y = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_OWN_WIDTH    = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_OWN_HEIGHT   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_OWN_DIAMETER = 3'd5;

    // which test an item goes through
    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_BOX,
        MODE_ROUND
    } mode_t;

    // per-axis result of the interval stage
    typedef struct packed {
        logic between; // strictly between lo and hi
        logic far;     // distance to the interval reaches the radius
    } axis_flags_t;

endpackage

// ===== rtl/sot_axis_dist.sv =====
module sot_axis_dist #(
    parameter int COORD_BITS = 20
) (
    input  logic signed [COORD_BITS+2:0] c,
    input  logic signed [COORD_BITS+2:0] lo,
    input  logic signed [COORD_BITS+2:0] hi,
    input  logic        [COORD_BITS-1:0] r,
    output sot_pkg::axis_flags_t         flags,
    output logic        [COORD_BITS-1:0] mag
);

    localparam int EW = COORD_BITS + 3;

    logic below;
    logic above;
    logic [EW-1:0] gap;

    assign below = c < lo;
    assign above = c > hi;

    // distance from the point to its clamp on the interval, never negative
    always_comb begin
        if (below) begin
            gap = EW'(lo - c);
        end else if (above) begin
            gap = EW'(c - hi);
        end else begin
            gap = '0;
        end
    end

    assign flags.between = (lo < c) && (c < hi);
    assign flags.far     = gap >= {{(EW-COORD_BITS){1'b0}}, r};
    // only meaningful when not far, then it fits below r
    assign mag = gap[COORD_BITS-1:0];

endmodule

// ===== rtl/shape_overlap_test_core.sv =====
// shape overlap test, box/box by interval overlap, circle cases by clamped squared distance
// throughput: one item per cycle while the output is not stalled, through
// a six-register pipeline with per-stage flow control
// a stall at the output backs up one stage at a time, bubbles are squeezed out
// reset clears all pipeline valid bits and loads the configuration reset values
module shape_overlap_test_core #(
    parameter int COORD_BITS = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sot_pkg::REG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_both_present,
    input  logic signed [COORD_BITS-1:0] s_own_world_x,
    input  logic signed [COORD_BITS-1:0] s_own_world_y,
    input  logic                         s_other_is_box,
    input  logic signed [COORD_BITS-1:0] s_other_world_x,
    input  logic signed [COORD_BITS-1:0] s_other_world_y,
    input  logic signed [COORD_BITS-1:0] s_other_offset_x,
    input  logic signed [COORD_BITS-1:0] s_other_offset_y,
    input  logic        [COORD_BITS-2:0] s_other_width,
    input  logic        [COORD_BITS-2:0] s_other_height,
    input  logic        [COORD_BITS-2:0] s_other_diameter,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_overlapping
);

    localparam int CB = COORD_BITS;
    localparam int SB = COORD_BITS - 1;   // size fields
    localparam int CW = COORD_BITS + 2;   // doubled centres
    localparam int EW = COORD_BITS + 3;   // interval ends
    localparam int PW = 2 * COORD_BITS;   // squares

    // configuration
    logic                 own_is_box_reg;
    logic signed [CB-1:0] own_offset_x_reg;
    logic signed [CB-1:0] own_offset_y_reg;
    logic        [SB-1:0] own_width_reg;
    logic        [SB-1:0] own_height_reg;
    logic        [SB-1:0] own_diameter_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_is_box_reg   <= 1'b1;
            own_offset_x_reg <= '0;
            own_offset_y_reg <= '0;
            own_width_reg    <= '0;
            own_height_reg   <= '0;
            own_diameter_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sot_pkg::REG_OWN_IS_BOX:   own_is_box_reg   <= cfg_data[0];
                sot_pkg::REG_OWN_OFFSET_X: own_offset_x_reg <= cfg_data;
                sot_pkg::REG_OWN_OFFSET_Y: own_offset_y_reg <= cfg_data;
                sot_pkg::REG_OWN_WIDTH:    own_width_reg    <= cfg_data[SB-1:0];
                sot_pkg::REG_OWN_HEIGHT:   own_height_reg   <= cfg_data[SB-1:0];
                sot_pkg::REG_OWN_DIAMETER: own_diameter_reg <= cfg_data[SB-1:0];
                default: ;
            endcase
        end
    end

    // flow control, each stage moves when empty or when the next one moves
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg, p5_valid_reg;
    logic m_valid_reg;
    logic p1_adv, p2_adv, p3_adv, p4_adv, p5_adv, out_adv;

    assign out_adv = !m_valid_reg || m_ready;
    assign p5_adv  = !p5_valid_reg || out_adv;
    assign p4_adv  = !p4_valid_reg || p5_adv;
    assign p3_adv  = !p3_valid_reg || p4_adv;
    assign p2_adv  = !p2_valid_reg || p3_adv;
    assign p1_adv  = !p1_valid_reg || p2_adv;
    assign s_ready = p1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (p1_adv)  p1_valid_reg <= s_valid;
            if (p2_adv)  p2_valid_reg <= p1_valid_reg;
            if (p3_adv)  p3_valid_reg <= p2_valid_reg;
            if (p4_adv)  p4_valid_reg <= p3_valid_reg;
            if (p5_adv)  p5_valid_reg <= p4_valid_reg;
            if (out_adv) m_valid_reg  <= p5_valid_reg;
        end
    end

    // stage 1: input register
    logic                 p1_present_reg;
    logic signed [CB-1:0] p1_own_wx_reg, p1_own_wy_reg;
    logic                 p1_other_box_reg;
    logic signed [CB-1:0] p1_other_wx_reg, p1_other_wy_reg;
    logic signed [CB-1:0] p1_other_ox_reg, p1_other_oy_reg;
    logic        [SB-1:0] p1_other_w_reg, p1_other_h_reg, p1_other_d_reg;

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            p1_present_reg   <= s_both_present;
            p1_own_wx_reg    <= s_own_world_x;
            p1_own_wy_reg    <= s_own_world_y;
            p1_other_box_reg <= s_other_is_box;
            p1_other_wx_reg  <= s_other_world_x;
            p1_other_wy_reg  <= s_other_world_y;
            p1_other_ox_reg  <= s_other_offset_x;
            p1_other_oy_reg  <= s_other_offset_y;
            p1_other_w_reg   <= s_other_width;
            p1_other_h_reg   <= s_other_height;
            p1_other_d_reg   <= s_other_diameter;
        end
    end

    // stage 2: doubled centres, test selection, half sizes and radius
    logic [CB:0]   cen_ax, cen_ay, cen_bx, cen_by;
    logic [CW-1:0] ax, ay, bx, by;

    assign cen_ax = {p1_own_wx_reg[CB-1], p1_own_wx_reg}
                  + {own_offset_x_reg[CB-1], own_offset_x_reg};
    assign cen_ay = {p1_own_wy_reg[CB-1], p1_own_wy_reg}
                  + {own_offset_y_reg[CB-1], own_offset_y_reg};
    assign cen_bx = {p1_other_wx_reg[CB-1], p1_other_wx_reg}
                  + {p1_other_ox_reg[CB-1], p1_other_ox_reg};
    assign cen_by = {p1_other_wy_reg[CB-1], p1_other_wy_reg}
                  + {p1_other_oy_reg[CB-1], p1_other_oy_reg};
    assign ax = {cen_ax, 1'b0};
    assign ay = {cen_ay, 1'b0};
    assign bx = {cen_bx, 1'b0};
    assign by = {cen_by, 1'b0};

    sot_pkg::mode_t p2_mode_next, p2_mode_reg;
    logic [CW-1:0]  p2_cx_next, p2_cy_next, p2_qx_next, p2_qy_next;
    logic [CW-1:0]  p2_cx_reg, p2_cy_reg, p2_qx_reg, p2_qy_reg;
    logic [CB-1:0]  p2_hw_next, p2_hh_next, p2_r_next;
    logic [CB-1:0]  p2_hw_reg, p2_hh_reg, p2_r_reg;

    // circle against circle is a circle against a zero-size box at the other centre
    always_comb begin
        p2_cx_next = ax;
        p2_cy_next = ay;
        p2_qx_next = bx;
        p2_qy_next = by;
        p2_hw_next = '0;
        p2_hh_next = '0;
        p2_r_next  = {1'b0, own_diameter_reg} + {1'b0, p1_other_d_reg};
        if (!p1_present_reg) begin
            p2_mode_next = sot_pkg::MODE_NONE;
        end else if (own_is_box_reg && p1_other_box_reg) begin
            p2_mode_next = sot_pkg::MODE_BOX;
        end else begin
            p2_mode_next = sot_pkg::MODE_ROUND;
        end
        if (own_is_box_reg && p1_other_box_reg) begin
            // box pair overlaps when the doubled centre gap is below the summed sizes on both axes
            p2_hw_next = {1'b0, own_width_reg} + {1'b0, p1_other_w_reg};
            p2_hh_next = {1'b0, own_height_reg} + {1'b0, p1_other_h_reg};
        end else if (own_is_box_reg) begin
            p2_cx_next = bx;
            p2_cy_next = by;
            p2_qx_next = ax;
            p2_qy_next = ay;
            p2_hw_next = {1'b0, own_width_reg};
            p2_hh_next = {1'b0, own_height_reg};
            p2_r_next  = {1'b0, p1_other_d_reg};
        end else if (p1_other_box_reg) begin
            p2_hw_next = {1'b0, p1_other_w_reg};
            p2_hh_next = {1'b0, p1_other_h_reg};
            p2_r_next  = {1'b0, own_diameter_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_adv) begin
            p2_mode_reg <= p2_mode_next;
            p2_cx_reg   <= p2_cx_next;
            p2_cy_reg   <= p2_cy_next;
            p2_qx_reg   <= p2_qx_next;
            p2_qy_reg   <= p2_qy_next;
            p2_hw_reg   <= p2_hw_next;
            p2_hh_reg   <= p2_hh_next;
            p2_r_reg    <= p2_r_next;
        end
    end

    // stage 3: interval ends around the box centre
    sot_pkg::mode_t       p3_mode_reg;
    logic signed [EW-1:0] p3_cx_reg, p3_cy_reg;
    logic signed [EW-1:0] p3_lox_reg, p3_hix_reg, p3_loy_reg, p3_hiy_reg;
    logic        [CB-1:0] p3_r_reg;
    logic [EW-1:0] qx_ext, qy_ext, hw_ext, hh_ext;

    assign qx_ext = {{(EW-CW){p2_qx_reg[CW-1]}}, p2_qx_reg};
    assign qy_ext = {{(EW-CW){p2_qy_reg[CW-1]}}, p2_qy_reg};
    assign hw_ext = {{(EW-CB){1'b0}}, p2_hw_reg};
    assign hh_ext = {{(EW-CB){1'b0}}, p2_hh_reg};

    always_ff @(posedge aclk) begin
        if (p3_adv) begin
            p3_mode_reg <= p2_mode_reg;
            p3_cx_reg   <= {{(EW-CW){p2_cx_reg[CW-1]}}, p2_cx_reg};
            p3_cy_reg   <= {{(EW-CW){p2_cy_reg[CW-1]}}, p2_cy_reg};
            p3_lox_reg  <= qx_ext - hw_ext;
            p3_hix_reg  <= qx_ext + hw_ext;
            p3_loy_reg  <= qy_ext - hh_ext;
            p3_hiy_reg  <= qy_ext + hh_ext;
            p3_r_reg    <= p2_r_reg;
        end
    end

    // stage 4: clamp distance per axis
    sot_pkg::axis_flags_t flags_x, flags_y;
    logic [CB-1:0]        mag_x, mag_y;

    sot_axis_dist #(.COORD_BITS(COORD_BITS)) u_dist_x (
        .c     (p3_cx_reg),
        .lo    (p3_lox_reg),
        .hi    (p3_hix_reg),
        .r     (p3_r_reg),
        .flags (flags_x),
        .mag   (mag_x)
    );

    sot_axis_dist #(.COORD_BITS(COORD_BITS)) u_dist_y (
        .c     (p3_cy_reg),
        .lo    (p3_loy_reg),
        .hi    (p3_hiy_reg),
        .r     (p3_r_reg),
        .flags (flags_y),
        .mag   (mag_y)
    );

    sot_pkg::mode_t p4_mode_reg;
    logic           p4_box_hit_reg, p4_far_reg;
    logic [CB-1:0]  p4_magx_reg, p4_magy_reg, p4_r_reg;

    always_ff @(posedge aclk) begin
        if (p4_adv) begin
            p4_mode_reg    <= p3_mode_reg;
            p4_box_hit_reg <= flags_x.between && flags_y.between;
            p4_far_reg     <= flags_x.far || flags_y.far;
            p4_magx_reg    <= mag_x;
            p4_magy_reg    <= mag_y;
            p4_r_reg       <= p3_r_reg;
        end
    end

    // stage 5: squares
    sot_pkg::mode_t p5_mode_reg;
    logic           p5_box_hit_reg, p5_far_reg;
    logic [PW-1:0]  p5_sqx_reg, p5_sqy_reg, p5_rr_reg;

    always_ff @(posedge aclk) begin
        if (p5_adv) begin
            p5_mode_reg    <= p4_mode_reg;
            p5_box_hit_reg <= p4_box_hit_reg;
            p5_far_reg     <= p4_far_reg;
            p5_sqx_reg     <= PW'(p4_magx_reg) * PW'(p4_magx_reg);
            p5_sqy_reg     <= PW'(p4_magy_reg) * PW'(p4_magy_reg);
            p5_rr_reg      <= PW'(p4_r_reg) * PW'(p4_r_reg);
        end
    end

    // output register
    logic [PW:0] dist_sq;
    logic        hit_next;
    logic        m_overlapping_reg;

    assign dist_sq = {1'b0, p5_sqx_reg} + {1'b0, p5_sqy_reg};

    always_comb begin
        case (p5_mode_reg)
            sot_pkg::MODE_BOX:   hit_next = p5_box_hit_reg;
            sot_pkg::MODE_ROUND: hit_next = !p5_far_reg && (dist_sq < {1'b0, p5_rr_reg});
            default:             hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            m_overlapping_reg <= hit_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_overlapping = m_overlapping_reg;

endmodule
